// ===== rtl/core/mlqs_pkg.sv =====
// shared constants, codes and control structs for the multilevel queue scheduler
`timescale 1ns / 1ps
package mlqs_pkg;

  localparam int NUM_PRIO_DEF    = 8;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_BITS_DEF     = 8;

  typedef enum logic {
    CMD_ADD  = 1'b0,
    CMD_PICK = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_ADDED   = 2'd0,
    ST_DROPPED = 2'd1,
    ST_PICKED  = 2'd2,
    ST_NONE    = 2'd3
  } status_t;

  // per-level flag update toward the scanner
  typedef struct packed {
    logic ne_wr;
    logic ne_val;
    logic cr_wr;
    logic cr_val;
  } scan_upd_t;

  // scanner outcome, valid while done is high
  typedef struct packed {
    logic done;
    logic found;
    logic reload;
  } scan_res_t;

endpackage

// ===== rtl/core/mlq_slot_scheduler.sv =====
// top level of the multilevel queue scheduler with per-level slot credit
`timescale 1ns / 1ps
// Multilevel queue scheduler. Each of NUM_PRIO levels keeps a FIFO of up to
// QUEUE_DEPTH process ids and a slot credit that starts at NUM_PRIO minus the
// level. An add item (command 0) appends proc_id to its level and reports
// added or dropped-when-full; a pick item (command 1) serves the lowest busy
// level with credit, reloading all credits when every busy level is out.
// One item is in flight at a time. An add reads the level state, updates it
// and writes the id, then its result moves to the output register. A pick
// runs the level scanner, which checks one level per cycle and stops at the
// first busy level with credit, then the level state and the id memory are
// each read once through their registered ports. A pick that finds every
// level empty ends after the full scan. The next item is accepted while a
// result still waits in the output register. After reset the block is ready
// at once.
module mlq_slot_scheduler #(
  parameter int NUM_PRIO    = mlqs_pkg::NUM_PRIO_DEF,
  parameter int QUEUE_DEPTH = mlqs_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = mlqs_pkg::ID_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       command,
  input  logic [7:0] proc_id,
  input  logic [2:0] priority_req,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] status,
  output logic [7:0] picked_id,
  output logic [2:0] picked_level
);

  localparam int LVL_W   = $clog2(NUM_PRIO);
  localparam int IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int CR_W    = $clog2(NUM_PRIO + 1);
  localparam int LS_W    = 2 * IDX_W + CNT_W;
  localparam int FDEPTH  = NUM_PRIO * (2 ** IDX_W);
  localparam int FADDR_W = LVL_W + IDX_W;

  typedef enum logic [7:0] {
    S_IDLE      = 8'b00000001,
    S_ADD_RD    = 8'b00000010,
    S_ADD_UPD   = 8'b00000100,
    S_SCAN      = 8'b00001000,
    S_PICK_RD   = 8'b00010000,
    S_PICK_UPD  = 8'b00100000,
    S_PICK_DATA = 8'b01000000,
    S_FIN       = 8'b10000000
  } state_t;

  state_t state;

  logic [LVL_W-1:0]   lvl;
  logic [ID_BITS-1:0] pid;
  mlqs_pkg::status_t  res_status;
  logic [ID_BITS-1:0] res_id;
  logic [LVL_W-1:0]   res_lvl;

  logic [NUM_PRIO-1:0] lvl_vld;
  logic [NUM_PRIO-1:0] cr_vld;
  logic                lrd_vld;
  logic                crd_vld;

  // input conversion
  logic [LVL_W+2:0]   pr_ext;
  logic [LVL_W-1:0]   lvl_in;
  logic [ID_BITS+7:0] pid_ext;
  logic               accept;

  assign accept  = in_valid & in_ready;
  assign pr_ext  = (LVL_W + 3)'(priority_req);
  assign lvl_in  = (32'(priority_req) >= NUM_PRIO) ? LVL_W'(NUM_PRIO - 1) : pr_ext[LVL_W-1:0];
  assign pid_ext = (ID_BITS + 8)'(proc_id);
  assign in_ready = (state == S_IDLE);

  // level state memory: {head, tail, fill}
  logic              lram_we;
  logic [LS_W-1:0]   lram_wdata;
  logic [LS_W-1:0]   lram_rdata;
  logic [LS_W-1:0]   lword;
  logic [IDX_W-1:0]  head;
  logic [IDX_W-1:0]  tail;
  logic [CNT_W-1:0]  fill;
  logic [IDX_W-1:0]  head_inc;
  logic [IDX_W-1:0]  tail_inc;

  assign lword              = lrd_vld ? lram_rdata : '0;
  assign {head, tail, fill} = lword;
  assign head_inc = (head == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_inc = (tail == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;

  mlqs_ram #(
    .WIDTH(LS_W),
    .DEPTH(NUM_PRIO)
  ) u_lvl_ram (
    .clk  (clk),
    .we   (lram_we),
    .waddr(lvl),
    .wdata(lram_wdata),
    .raddr(lvl),
    .rdata(lram_rdata)
  );

  // credit memory, unwritten entries read as their reset credit
  logic            cram_we;
  logic [CR_W-1:0] cram_rdata;
  logic [CR_W-1:0] credit;

  assign credit = crd_vld ? cram_rdata : CR_W'(NUM_PRIO) - CR_W'(lvl);

  mlqs_ram #(
    .WIDTH(CR_W),
    .DEPTH(NUM_PRIO)
  ) u_cr_ram (
    .clk  (clk),
    .we   (cram_we),
    .waddr(lvl),
    .wdata(credit - 1'b1),
    .raddr(lvl),
    .rdata(cram_rdata)
  );

  // process id memory, one row of slots per level
  logic               fram_we;
  logic [ID_BITS-1:0] fram_rdata;

  mlqs_ram #(
    .WIDTH(ID_BITS),
    .DEPTH(FDEPTH)
  ) u_fifo_ram (
    .clk  (clk),
    .we   (fram_we),
    .waddr(FADDR_W'({lvl, tail})),
    .wdata(pid),
    .raddr(FADDR_W'({lvl, head})),
    .rdata(fram_rdata)
  );

  // level scanner
  mlqs_pkg::scan_upd_t scan_upd;
  mlqs_pkg::scan_res_t scan_res;
  logic [LVL_W-1:0]    scan_lvl;
  logic                scan_start;

  assign scan_start = accept & (command == mlqs_pkg::CMD_PICK);

  mlqs_scan #(
    .NUM_PRIO(NUM_PRIO)
  ) u_scan (
    .clk    (clk),
    .rst    (rst),
    .start  (scan_start),
    .upd    (scan_upd),
    .upd_lvl(lvl),
    .res    (scan_res),
    .res_lvl(scan_lvl)
  );

  logic add_ok;
  assign add_ok = (fill != CNT_W'(QUEUE_DEPTH));

  always_comb begin
    lram_we    = 1'b0;
    lram_wdata = lword;
    cram_we    = 1'b0;
    fram_we    = 1'b0;
    scan_upd   = '0;
    unique case (state)
      S_ADD_UPD: begin
        if (add_ok) begin
          fram_we         = 1'b1;
          lram_we         = 1'b1;
          lram_wdata      = {head, tail_inc, fill + 1'b1};
          scan_upd.ne_wr  = 1'b1;
          scan_upd.ne_val = 1'b1;
        end
      end
      S_PICK_UPD: begin
        lram_we         = 1'b1;
        lram_wdata      = {head_inc, tail, fill - 1'b1};
        scan_upd.ne_wr  = 1'b1;
        scan_upd.ne_val = (fill != CNT_W'(1));
        if (credit != '0) begin
          cram_we         = 1'b1;
          scan_upd.cr_wr  = 1'b1;
          scan_upd.cr_val = (credit != CR_W'(1));
        end
      end
      S_IDLE, S_ADD_RD, S_SCAN, S_PICK_RD, S_PICK_DATA, S_FIN: begin
      end
      default: begin
      end
    endcase
  end

  // sequencer and valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      lvl_vld   <= '0;
      cr_vld    <= '0;
      lrd_vld   <= 1'b0;
      crd_vld   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      lrd_vld <= lvl_vld[lvl];
      crd_vld <= cr_vld[lvl];
      if (out_valid && out_ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= (command == mlqs_pkg::CMD_PICK) ? S_SCAN : S_ADD_RD;
          end
        end
        S_ADD_RD: begin
          state <= S_ADD_UPD;
        end
        S_ADD_UPD: begin
          if (add_ok) begin
            lvl_vld[lvl] <= 1'b1;
          end
          state <= S_FIN;
        end
        S_SCAN: begin
          if (scan_res.done) begin
            if (!scan_res.found) begin
              state <= S_FIN;
            end else begin
              if (scan_res.reload) begin
                cr_vld <= '0;
              end
              state <= S_PICK_RD;
            end
          end
        end
        S_PICK_RD: begin
          state <= S_PICK_UPD;
        end
        S_PICK_UPD: begin
          if (credit != '0) begin
            cr_vld[lvl] <= 1'b1;
          end
          state <= S_PICK_DATA;
        end
        S_PICK_DATA: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // item payload and result registers
  logic [ID_BITS+7:0] id_ext;
  logic [LVL_W+2:0]   lvl_ext;

  assign id_ext  = (ID_BITS + 8)'(res_id);
  assign lvl_ext = (LVL_W + 3)'(res_lvl);

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          pid <= pid_ext[ID_BITS-1:0];
          lvl <= (command == mlqs_pkg::CMD_PICK) ? '0 : lvl_in;
        end
      end
      S_ADD_UPD: begin
        res_status <= add_ok ? mlqs_pkg::ST_ADDED : mlqs_pkg::ST_DROPPED;
        res_id     <= '0;
        res_lvl    <= '0;
      end
      S_SCAN: begin
        if (scan_res.done) begin
          lvl        <= scan_lvl;
          res_status <= mlqs_pkg::ST_NONE;
          res_id     <= '0;
          res_lvl    <= '0;
        end
      end
      S_PICK_DATA: begin
        res_status <= mlqs_pkg::ST_PICKED;
        res_id     <= fram_rdata;
        res_lvl    <= lvl;
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          status       <= res_status;
          picked_id    <= id_ext[7:0];
          picked_level <= lvl_ext[2:0];
        end
      end
      S_ADD_RD, S_PICK_RD, S_PICK_UPD: begin
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/core/mlqs_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module mlqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/mlqs_scan.sv =====
// level scanner: walks one level a cycle over the non-empty and has-credit flags
`timescale 1ns / 1ps
module mlqs_scan #(
  parameter int NUM_PRIO = mlqs_pkg::NUM_PRIO_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  mlqs_pkg::scan_upd_t         upd,
  input  logic [$clog2(NUM_PRIO)-1:0] upd_lvl,
  output mlqs_pkg::scan_res_t         res,
  output logic [$clog2(NUM_PRIO)-1:0] res_lvl
);

  localparam int LVL_W = $clog2(NUM_PRIO);
  localparam logic [LVL_W-1:0] LAST = LVL_W'(NUM_PRIO - 1);

  logic                active;
  logic [LVL_W-1:0]    cnt;
  logic                any_seen;
  logic [LVL_W-1:0]    first;
  logic [NUM_PRIO-1:0] nonempty;
  logic [NUM_PRIO-1:0] crok;

  logic             ne_cur;
  logic             hit;
  logic             any_now;
  logic [LVL_W-1:0] first_now;

  always_comb begin
    ne_cur     = nonempty[cnt];
    hit        = ne_cur & crok[cnt];
    any_now    = any_seen | ne_cur;
    first_now  = any_seen ? first : cnt;
    res.done   = active & (hit | (cnt == LAST));
    res.found  = hit | any_now;
    res.reload = ~hit & any_now;
    res_lvl    = hit ? cnt : first_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      cnt      <= '0;
      any_seen <= 1'b0;
      first    <= '0;
      nonempty <= '0;
      crok     <= '1;
    end else begin
      if (start) begin
        active   <= 1'b1;
        cnt      <= '0;
        any_seen <= 1'b0;
      end else if (active) begin
        if (res.done) begin
          active <= 1'b0;
        end else begin
          cnt <= cnt + 1'b1;
        end
        if (ne_cur && !any_seen) begin
          any_seen <= 1'b1;
          first    <= cnt;
        end
      end
      // every busy level out of credit: all levels get credit again
      if (res.done && res.reload) begin
        crok <= '1;
      end
      if (upd.ne_wr) begin
        nonempty[upd_lvl] <= upd.ne_val;
      end
      if (upd.cr_wr) begin
        crok[upd_lvl] <= upd.cr_val;
      end
    end
  end

endmodule

// ===== test/tb_mlq_slot_scheduler.sv =====
// self-checking testbench for the multilevel queue scheduler with slot credit
`timescale 1ns / 1ps
module tb_mlq_slot_scheduler;

  localparam int NP         = mlqs_pkg::NUM_PRIO_DEF;
  localparam int QD         = mlqs_pkg::QUEUE_DEPTH_DEF;
  localparam int RAND_ITEMS = 800;
  localparam int STALL_PCT  = 31;
  localparam int IDLE_LIMIT = 4000;

  typedef struct {
    mlqs_pkg::status_t st;
    logic [7:0]        id;
    logic [2:0]        lvl;
  } sched_outcome_t;

  // predicts the scheduler's answer to each item and compares the results
  class sched_scoreboard;
    logic [7:0]     id_mem[NP][QD];
    int             head[NP];
    int             tail[NP];
    int             fill[NP];
    int             credit[NP];
    sched_outcome_t pending[$];
    int             errors;
    int             n_added, n_dropped, n_picked, n_none, n_reload;

    function new();
      for (int lv = 0; lv < NP; lv++) begin
        head[lv]   = 0;
        tail[lv]   = 0;
        fill[lv]   = 0;
        credit[lv] = NP - lv;
      end
      errors    = 0;
      n_added   = 0;
      n_dropped = 0;
      n_picked  = 0;
      n_none    = 0;
      n_reload  = 0;
    endfunction

    function automatic void serve_level(int lv, ref sched_outcome_t res);
      res.st  = mlqs_pkg::ST_PICKED;
      res.id  = id_mem[lv][head[lv]];
      res.lvl = 3'(lv);
      head[lv] = (head[lv] + 1) % QD;
      fill[lv]--;
      if (credit[lv] > 0) credit[lv]--;
      n_picked++;
    endfunction

    function automatic void note_item(mlqs_pkg::cmd_t cmd, logic [7:0] pid,
                                      logic [2:0] prio);
      sched_outcome_t res;
      int             lv;
      int             first;
      bit             served;
      res.st  = mlqs_pkg::ST_NONE;
      res.id  = '0;
      res.lvl = '0;
      first   = -1;
      served  = 0;
      if (cmd == mlqs_pkg::CMD_ADD) begin
        lv = (int'(prio) >= NP) ? NP - 1 : int'(prio);
        if (fill[lv] >= QD) begin
          res.st = mlqs_pkg::ST_DROPPED;
          n_dropped++;
        end else begin
          id_mem[lv][tail[lv]] = pid;
          tail[lv] = (tail[lv] + 1) % QD;
          fill[lv]++;
          res.st = mlqs_pkg::ST_ADDED;
        end
        n_added++;
      end else begin
        for (int i = 0; i < NP && !served; i++) begin
          if (fill[i] != 0) begin
            if (first < 0) first = i;
            if (credit[i] > 0) begin
              serve_level(i, res);
              served = 1;
            end
          end
        end
        if (first < 0) begin
          n_none++;
        end else if (!served) begin
          // every busy level is out of credit
          for (int i = 0; i < NP; i++) credit[i] = NP - i;
          n_reload++;
          serve_level(first, res);
        end
      end
      pending.push_back(res);
    endfunction

    function automatic void check_result(logic [1:0] st, logic [7:0] id, logic [2:0] lvl);
      sched_outcome_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result status=%0d id=%0d level=%0d",
                 $time, st, id, lvl);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (st !== want.st) begin
        $display("%0t: status mismatch, expected %0d actual %0d", $time, want.st, st);
        errors++;
      end
      if (id !== want.id) begin
        $display("%0t: picked_id mismatch, expected %0d actual %0d", $time, want.id, id);
        errors++;
      end
      if (lvl !== want.lvl) begin
        $display("%0t: picked_level mismatch, expected %0d actual %0d",
                 $time, want.lvl, lvl);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic       command;
  logic [7:0] proc_id;
  logic [2:0] priority_req;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] status;
  logic [7:0] picked_id;
  logic [2:0] picked_level;

  sched_scoreboard sb;
  bit              steady;
  int              idle_cycles;

  mlq_slot_scheduler dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .proc_id      (proc_id),
    .priority_req (priority_req),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .picked_id    (picked_id),
    .picked_level (picked_level)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(input mlqs_pkg::cmd_t cmd, input logic [7:0] pid,
                           input logic [2:0] prio);
    while (!steady && $urandom_range(0, 99) < STALL_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    command      = cmd;
    proc_id      = pid;
    priority_req = prio;
    do @(posedge clk); while (!in_ready);
    sb.note_item(cmd, pid, prio);
    @(negedge clk);
  endtask

  // result side: random back-pressure, none during the steady stretch
  always @(negedge clk) begin
    if (rst) begin
      out_ready = 1'b0;
    end else begin
      out_ready = steady || ($urandom_range(0, 99) >= STALL_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(status, picked_id, picked_level);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: timeout, no item moved for %0d cycles", $time, IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int             n;
    int             burst;
    int             add_pct;
    int             hot_a;
    int             hot_b;
    mlqs_pkg::cmd_t cmd;
    logic [2:0]     prio;

    sb           = new();
    rst          = 1'b1;
    in_valid     = 1'b0;
    command      = mlqs_pkg::CMD_ADD;
    proc_id      = '0;
    priority_req = '0;
    out_ready    = 1'b0;
    steady       = 1'b0;
    idle_cycles  = 0;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // pick with nothing queued
    send_item(mlqs_pkg::CMD_PICK, 8'hff, 3'd7);
    // extreme ids on the last level, then drain it past its single credit
    send_item(mlqs_pkg::CMD_ADD, 8'h00, 3'd7);
    send_item(mlqs_pkg::CMD_ADD, 8'hff, 3'd7);
    send_item(mlqs_pkg::CMD_PICK, 8'h00, 3'd0);
    send_item(mlqs_pkg::CMD_PICK, 8'h5a, 3'd0);
    // fill one level, the last add overflows
    for (int k = 0; k <= QD; k++) send_item(mlqs_pkg::CMD_ADD, 8'(8'h40 + k), 3'd3);
    send_item(mlqs_pkg::CMD_ADD, 8'h01, 3'd0);
    send_item(mlqs_pkg::CMD_PICK, 8'h00, 3'd0);
    send_item(mlqs_pkg::CMD_PICK, 8'h00, 3'd0);

    // bursts with a varying add/pick mix, levels leaning on a hot pair
    n = 0;
    while (n < RAND_ITEMS) begin
      burst = $urandom_range(20, 60);
      case ($urandom_range(0, 3))
        0:       add_pct = 25;
        1:       add_pct = 50;
        2:       add_pct = 75;
        default: add_pct = 90;
      endcase
      hot_a = $urandom_range(0, NP - 1);
      hot_b = $urandom_range(0, NP - 1);
      for (int j = 0; j < burst && n < RAND_ITEMS; j++) begin
        cmd = ($urandom_range(0, 99) < add_pct) ? mlqs_pkg::CMD_ADD : mlqs_pkg::CMD_PICK;
        if ($urandom_range(0, 1)) prio = 3'($urandom_range(0, 1) ? hot_a : hot_b);
        else                      prio = 3'($urandom_range(0, 7));
        steady = (n >= 300 && n < 420);
        send_item(cmd, 8'($urandom), prio);
        n++;
      end
    end
    steady   = 1'b0;
    in_valid = 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (NP + 8) @(posedge clk);

    $display("covered %0d adds (%0d dropped on a full level) and %0d picks",
             sb.n_added, sb.n_dropped, sb.n_picked + sb.n_none);
    $display("%0d picks found nothing ready, %0d picks reloaded the credits",
             sb.n_none, sb.n_reload);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/mlqs_pkg.sv
rtl/core/mlqs_ram.sv
rtl/core/mlqs_scan.sv
rtl/core/mlq_slot_scheduler.sv
test/tb_mlq_slot_scheduler.sv
